/* sv/rlfe_pkg.sv */
// Shared types, constants and helpers for the RGB LED fade engine.
`timescale 1ns / 1ps

package rlfe_pkg;

  // Number of LEDs in the chain and the width of an LED address
  localparam int NUM_LEDS = 16;
  localparam int LED_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  // Width of the fade duration, also the number of divider steps
  localparam int DUR_W = 16;

  // Register reset value
  localparam logic [7:0] INTERVAL_RESET = 8'd50;

  // Transaction kinds
  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_FADE = 2'd1;
  localparam logic [1:0] KIND_GET  = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  // Channel codes, in frame order
  localparam logic [1:0] CH_G = 2'd0;
  localparam logic [1:0] CH_R = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  typedef struct packed {
    logic [7:0] g;
    logic [7:0] r;
    logic [7:0] b;
  } colour_t;

  // One LED's stored state
  typedef struct packed {
    colour_t target;
    colour_t current;
    colour_t step;
  } entry_t;

  // Operands for one step computation
  typedef struct packed {
    logic [7:0]       diff;
    logic [7:0]       interval;
    logic [DUR_W-1:0] dur;
  } div_req_t;

  // Pick one channel of a colour
  function automatic logic [7:0] colour_ch(colour_t c, logic [1:0] ch);
    logic [7:0] v;
    begin
      case (ch)
        CH_G:    v = c.g;
        CH_R:    v = c.r;
        default: v = c.b;
      endcase
      return v;
    end
  endfunction

endpackage

/* sv/rlfe_in_if.sv */
// Input channel: command transactions into the fade engine.
`timescale 1ns / 1ps

interface rlfe_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  led_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [15:0] duration_ms;

  modport source (output valid, kind, led_index, red, green, blue, duration_ms,
                  input ready);
  modport sink   (input valid, kind, led_index, red, green, blue, duration_ms,
                  output ready);
endinterface

/* sv/rlfe_out_if.sv */
// Output channel: result transactions from the fade engine.
`timescale 1ns / 1ps

interface rlfe_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_red;
  logic [7:0] read_green;
  logic [7:0] read_blue;
  logic [7:0] frame_byte;
  logic       last;

  modport source (output valid, status, read_red, read_green, read_blue, frame_byte,
                  last, input ready);
  modport sink   (input valid, status, read_red, read_green, read_blue, frame_byte,
                  last, output ready);
endinterface

/* sv/rlfe_cfg_if.sv */
// Configuration channel: writes of the update interval register.
`timescale 1ns / 1ps

interface rlfe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] update_interval_ms;

  modport source (output valid, update_interval_ms, input ready);
  modport sink   (input valid, update_interval_ms, output ready);
endinterface

/* sv/rlfe_ram.sv */
// Generic single-port-write, registered-read RAM holding the LED state.
`timescale 1ns / 1ps

module rlfe_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 72
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/rlfe_div.sv */
// Iterative step unit: ceil(diff * interval / duration), saturated to 8 bits.
`timescale 1ns / 1ps

module rlfe_div import rlfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  div_req_t   req_i,
  output logic       done_o,
  output logic [7:0] step_o
);

  localparam int CNT_W = $clog2(DUR_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DUR_W-1:0] quo_q, rem_q, dur_q;
  logic [DUR_W:0]   shifted, trial, ceil_val;

  // One restoring step: bring down the next dividend bit and try a subtract
  assign shifted = {rem_q, quo_q[DUR_W-1]};
  assign trial   = shifted - {1'b0, dur_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CNT_W'(DUR_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Datapath: product registered at start, then one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= DUR_W'({8'd0, req_i.diff} * {8'd0, req_i.interval});
      rem_q <= '0;
      dur_q <= req_i.dur;
    end else if (busy_q) begin
      if (!trial[DUR_W]) begin
        rem_q <= trial[DUR_W-1:0];
        quo_q <= {quo_q[DUR_W-2:0], 1'b1};
      end else begin
        rem_q <= shifted[DUR_W-1:0];
        quo_q <= {quo_q[DUR_W-2:0], 1'b0};
      end
    end
  end

  // Round up on any remainder, then clamp
  assign ceil_val = {1'b0, quo_q} + {{DUR_W{1'b0}}, (rem_q != '0)};
  assign step_o   = (ceil_val > (DUR_W + 1)'(255)) ? 8'hFF : ceil_val[7:0];
  assign done_o   = done_q;

endmodule

/* sv/rgb_led_fade_engine.sv */
// RGB LED fade engine, top level: sequencer around the LED state RAM.
// Set and get: result after the read, update and output steps; out of range goes straight to output.
// Fade set: the bit-serial step divider runs once per channel, G, R then B.
// Tick: per LED, one RAM read-modify-write and 3 bytes.
// One transaction at a time. Reset clears per-LED valid bits (LEDs read all zero), no
// clearing pass; the update interval resets to 50.
`timescale 1ns / 1ps

module rgb_led_fade_engine import rlfe_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  rlfe_in_if.sink   in_i,
  rlfe_out_if.source out_o,
  rlfe_cfg_if.sink  cfg_i
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_RD      = 4'd1;
  localparam logic [3:0] ST_EXEC    = 4'd2;
  localparam logic [3:0] ST_DSTART  = 4'd3;
  localparam logic [3:0] ST_DIV     = 4'd4;
  localparam logic [3:0] ST_RESP    = 4'd5;
  localparam logic [3:0] ST_TK_RD   = 4'd6;
  localparam logic [3:0] ST_TK_UPD  = 4'd7;
  localparam logic [3:0] ST_TK_EMIT = 4'd8;

  localparam logic [7:0]       IDX_LIMIT = 8'(NUM_LEDS);
  localparam logic [LED_W-1:0] LAST_LED  = LED_W'(NUM_LEDS - 1);

  // Move one channel toward its target by at most its step
  function automatic logic [7:0] step_toward(logic [7:0] cur, logic [7:0] tgt,
                                             logic [7:0] st);
    logic [7:0] gap;
    logic [7:0] res;
    begin
      res = cur;
      if (cur < tgt) begin
        gap = tgt - cur;
        res = cur + ((st < gap) ? st : gap);
      end else if (cur > tgt) begin
        gap = cur - tgt;
        res = cur - ((st < gap) ? st : gap);
      end
      return res;
    end
  endfunction

  // State and transaction registers
  logic [3:0]       state_q, state_d;
  logic [LED_W-1:0] led_q, led_d;
  logic [1:0]       byte_q, byte_d;
  logic [1:0]       ch_q, ch_d;
  logic [7:0]       interval_q;
  logic [1:0]       kind_q;
  logic [LED_W-1:0] idx_q;
  colour_t          col_q;
  logic [DUR_W-1:0] dur_q;
  logic             resp_status_q;
  colour_t          resp_rgb_q;
  colour_t          cur_q, step_q, frame_q;

  // Output register
  logic       out_valid_q, status_q, last_q;
  colour_t    rgb_q;
  logic [7:0] fb_q;

  // RAM and valid bits
  logic [NUM_LEDS-1:0] valid_q;
  logic                rvalid_q;
  logic                ram_we;
  logic [LED_W-1:0]    ram_waddr, ram_raddr;
  entry_t              ram_wdata, rd_raw, rd_entry;

  // Divider
  logic     div_start, div_done;
  logic [7:0] div_step;
  div_req_t div_req;

  // Control strobes
  logic       in_fire, out_free, out_load, resp_ld, cur_ld, step_ld, tk_ld;
  logic       o_status_d, o_last_d;
  colour_t    o_rgb_d, tk_next;
  logic [7:0] o_byte_d, diff_a, diff_b;

  assign in_fire     = in_i.valid && in_i.ready;
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign out_free    = !out_valid_q || out_o.ready;

  rlfe_ram #(
    .DEPTH (NUM_LEDS),
    .WIDTH ($bits(entry_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (rd_raw)
  );

  // Never-written entries read as zero
  assign rd_entry = rvalid_q ? rd_raw : '0;

  // Read address: prefetch next LED while the current one is shifted out
  always_comb begin
    case (state_q)
      ST_TK_RD:   ram_raddr = led_q;
      ST_TK_EMIT: ram_raddr = (led_q == LAST_LED) ? '0 : led_q + 1'b1;
      default:    ram_raddr = idx_q;
    endcase
  end

  // Tick update of all three channels
  assign tk_next.g = step_toward(rd_entry.current.g, rd_entry.target.g, rd_entry.step.g);
  assign tk_next.r = step_toward(rd_entry.current.r, rd_entry.target.r, rd_entry.step.r);
  assign tk_next.b = step_toward(rd_entry.current.b, rd_entry.target.b, rd_entry.step.b);

  // Step operands for the channel in hand
  assign diff_a = colour_ch(col_q, ch_q);
  assign diff_b = colour_ch(cur_q, ch_q);
  assign div_req.diff     = (diff_a > diff_b) ? diff_a - diff_b : diff_b - diff_a;
  assign div_req.interval = interval_q;
  assign div_req.dur      = dur_q;

  rlfe_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .step_o  (div_step)
  );

  // Sequencer
  always_comb begin
    state_d    = state_q;
    led_d      = led_q;
    byte_d     = byte_q;
    ch_d       = ch_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = '0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    resp_ld    = 1'b0;
    cur_ld     = 1'b0;
    step_ld    = 1'b0;
    tk_ld      = 1'b0;
    o_status_d = 1'b0;
    o_rgb_d    = '0;
    o_byte_d   = '0;
    o_last_d   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.kind == KIND_TICK) begin
            led_d   = '0;
            state_d = ST_TK_RD;
          end else if (in_i.led_index >= IDX_LIMIT) begin
            state_d = ST_RESP;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_d = ST_EXEC;
      end
      ST_EXEC: begin
        if (kind_q == KIND_GET) begin
          resp_ld = 1'b1;
          state_d = ST_RESP;
        end else if (kind_q == KIND_SET || dur_q == '0) begin
          ram_we    = 1'b1;
          ram_wdata = '{target: col_q, current: col_q, step: rd_entry.step};
          state_d   = ST_RESP;
        end else begin
          cur_ld  = 1'b1;
          ch_d    = CH_G;
          state_d = ST_DSTART;
        end
      end
      ST_DSTART: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          step_ld = 1'b1;
          if (ch_q == CH_B) begin
            ram_we    = 1'b1;
            ram_wdata = '{target: col_q, current: cur_q,
                          step: '{g: step_q.g, r: step_q.r, b: div_step}};
            state_d   = ST_RESP;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_DSTART;
          end
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_status_d = resp_status_q;
          o_rgb_d    = resp_rgb_q;
          o_last_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_TK_RD: begin
        state_d = ST_TK_UPD;
      end
      ST_TK_UPD: begin
        ram_we    = 1'b1;
        ram_waddr = led_q;
        ram_wdata = '{target: rd_entry.target, current: tk_next, step: rd_entry.step};
        tk_ld     = 1'b1;
        byte_d    = '0;
        state_d   = ST_TK_EMIT;
      end
      ST_TK_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          o_byte_d = colour_ch(frame_q, byte_q);
          o_last_d = (led_q == LAST_LED) && (byte_q == CH_B);
          if (byte_q == CH_B) begin
            byte_d = '0;
            if (led_q == LAST_LED) begin
              state_d = ST_IDLE;
            end else begin
              led_d   = led_q + 1'b1;
              state_d = ST_TK_UPD;
            end
          end else begin
            byte_d = byte_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      led_q       <= '0;
      byte_q      <= '0;
      ch_q        <= '0;
      interval_q  <= INTERVAL_RESET;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
      rvalid_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      led_q    <= led_d;
      byte_q   <= byte_d;
      ch_q     <= ch_d;
      rvalid_q <= valid_q[ram_raddr];
      if (cfg_i.valid) begin
        interval_q <= cfg_i.update_interval_ms;
      end
      if (ram_we) begin
        valid_q[ram_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q        <= in_i.kind;
      idx_q         <= in_i.led_index[LED_W-1:0];
      col_q         <= '{g: in_i.green, r: in_i.red, b: in_i.blue};
      dur_q         <= in_i.duration_ms;
      resp_status_q <= (in_i.kind != KIND_TICK) && (in_i.led_index >= IDX_LIMIT);
      resp_rgb_q    <= '0;
    end else if (resp_ld) begin
      resp_rgb_q <= rd_entry.target;
    end
    if (cur_ld) begin
      cur_q <= rd_entry.current;
    end
    if (step_ld) begin
      case (ch_q)
        CH_G:    step_q.g <= div_step;
        CH_R:    step_q.r <= div_step;
        default: step_q.b <= div_step;
      endcase
    end
    if (tk_ld) begin
      frame_q <= tk_next;
    end
    if (out_load) begin
      status_q <= o_status_d;
      rgb_q    <= o_rgb_d;
      fb_q     <= o_byte_d;
      last_q   <= o_last_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.read_red   = rgb_q.r;
  assign out_o.read_green = rgb_q.g;
  assign out_o.read_blue  = rgb_q.b;
  assign out_o.frame_byte = fb_q;
  assign out_o.last       = last_q;

  // Checks
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("input still ready after a transaction was taken");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !ram_we)
    else $error("RAM written while idle");

  a_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("step unit finished outside a fade set");

  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_q != 2'd3)
    else $error("frame byte counter out of range");

endmodule
